// ----- rtl/pss_pkg.sv -----
// Package for the positional sequence store: field widths, request and
// status codes, and the command and status structs between controller and datapath.
// No dependencies.
package pss_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int POS_W        = 9;
    localparam int VAL_W        = 64;
    localparam int TDATA_W      = 80;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_IGNORED = 2'd3
    } stat_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_INIT_INS,
        DP_INIT_DEL,
        DP_SHIFT_RD,
        DP_SHIFT_WR,
        DP_PUT,
        DP_READ,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        stat_t  st;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic in_range;
        logic shift_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/pss_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pss_ctrl.sv -----
// Controller state machine of the positional sequence store.
// Depends on pss_pkg for the command and status structs.
module pss_ctrl
    import pss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    stat_t  st_reg, st_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd.op     = DP_NOP;
        cmd.st     = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                st_next = ST_OK;
                if (stat.req inside {REQ_APPEND, REQ_INSERT})
                begin
                    if (stat.full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.op     = DP_INIT_INS;
                        state_next = S_CHK;
                    end
                end
                else if (stat.req == REQ_DELETE)
                begin
                    if (!stat.in_range)
                    begin
                        st_next    = ST_IGNORED;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.op     = DP_INIT_DEL;
                        state_next = S_CHK;
                    end
                end
                else
                begin
                    if (!stat.in_range)
                    begin
                        st_next    = ST_RANGE;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.op     = DP_READ;
                        state_next = S_RD_WAIT;
                    end
                end
            end
            S_CHK:
            begin
                if (!stat.shift_done)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (stat.req inside {REQ_APPEND, REQ_INSERT})
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.op     = DP_SHIFT_RD;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.op     = DP_SHIFT_WR;
                state_next = S_CHK;
            end
            S_PUT:
            begin
                cmd.op     = DP_PUT;
                state_next = S_FINISH;
            end
            S_RD_WAIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ----- rtl/pss_datapath.sv -----
// Datapath of the positional sequence store: request registers, element count,
// shift cursor, the sequence RAM and the result register.
// Depends on pss_pkg and pss_ram.
module pss_datapath
    import pss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         in_req,
    input  logic [POS_W-1:0]   in_pos,
    input  logic [VAL_W-1:0]   in_val,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VAL_W-1:0]   out_value,
    output logic [POS_W-1:0]   out_count,
    output logic [1:0]         out_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    req_t             req_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    cursor_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic [POS_W-1:0] out_count_reg;
    stat_t            out_status_reg;

    logic [MW-1:0]    pos_ext;
    logic [MW-1:0]    count_ext;
    logic             is_ins;
    logic             ok;

    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [VAL_W-1:0] ram_rdata;

    assign pos_ext   = MW'(pos_reg);
    assign count_ext = MW'(count_reg);
    assign is_ins    = (req_reg == REQ_APPEND) || (req_reg == REQ_INSERT);
    assign ok        = (cmd.st == ST_OK);

    assign stat.req        = req_reg;
    assign stat.full       = (count_reg == CW'(CAPACITY));
    assign stat.in_range   = (pos_ext < count_ext);
    assign stat.shift_done = is_ins ? (cursor_reg == idx_reg)
                                    : ((CW'(cursor_reg) + CW'(1)) == count_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = cursor_reg;
        ram_wdata = ram_rdata;
        ram_raddr = AW'(pos_ext);
        case (cmd.op)
            DP_READ:
            begin
                ram_re = 1'b1;
            end
            DP_SHIFT_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = is_ins ? (cursor_reg - AW'(1)) : (cursor_reg + AW'(1));
            end
            DP_SHIFT_WR:
            begin
                ram_we = 1'b1;
            end
            DP_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = val_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ok && is_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ok && (req_reg == REQ_DELETE))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Request registers and cursor hold payload only and need no reset.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LATCH:
            begin
                req_reg <= req_t'(in_req);
                pos_reg <= in_pos;
                val_reg <= in_val;
            end
            DP_INIT_INS:
            begin
                cursor_reg <= AW'(count_reg);
                if ((req_reg == REQ_APPEND) || (pos_ext > count_ext))
                begin
                    idx_reg <= AW'(count_reg);
                end
                else
                begin
                    idx_reg <= AW'(pos_ext);
                end
            end
            DP_INIT_DEL:
            begin
                cursor_reg <= AW'(pos_ext);
                idx_reg    <= AW'(pos_ext);
            end
            DP_SHIFT_WR:
            begin
                cursor_reg <= is_ins ? (cursor_reg - AW'(1)) : (cursor_reg + AW'(1));
            end
            DP_FINISH:
            begin
                out_value_reg  <= (ok && (req_reg == REQ_READ)) ? ram_rdata : '0;
                out_count_reg  <= POS_W'(count_next);
                out_status_reg <= cmd.st;
            end
            default:
            begin
                cursor_reg <= cursor_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == DP_FINISH)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    pss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // A full rejection is only reported when the store really is full.
    a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_FINISH && cmd.st == ST_FULL) |-> (count_reg == CW'(CAPACITY)))
        else $error("full status with room left");

    // A finished transaction is presented on the next cycle.
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_FINISH) |=> out_valid_reg)
        else $error("result not presented after finish");

    // A result is never overwritten while it still waits to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_FINISH) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

// ----- rtl/positional_sequence_store_core.sv -----
// Top level of the positional sequence store: an ordered sequence of signed
// 64-bit values with append, insert, delete and read at a position.
// Depends on pss_pkg, pss_ctrl, pss_datapath and pss_ram.
//
// Channel   Dir  Signals             Contents
// s_axis    in   tvalid/tready/...   request: tuser = req_type, tdata = position, item_value
// m_axis    out  tvalid/tready/...   result:  tuser = status, tdata = read_value, count
//
// One request is handled at a time. An insert or delete shifts the later elements
// one by one, and every moved element goes through a read and a write of the single
// sequence RAM; an append or a delete of the last element moves none.
// Reset clears the element count and the control state; the RAM is not cleared, since
// only entries below the count are ever read.
// The result register lets a new request be accepted while the previous result waits;
// that request then stalls in its final step until the result transaction completes.
module positional_sequence_store_core
    import pss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata from bit 0: position[8:0], item_value[72:9], zero fill [79:73]
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // tdata from bit 0: read_value[63:0], element_count[72:64], zero fill [79:73]
    output logic [TDATA_W-1:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]         m_axis_tuser
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [VAL_W-1:0] out_value;
    logic [POS_W-1:0] out_count;

    // The controller steps through one request; it only talks to the datapath
    // through the command and status structs.
    pss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath captures the request on the accepting edge, so the payload is
    // taken from the ports only when the controller issues its latch command.
    pss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_req     (s_axis_tuser),
        .in_pos     (s_axis_tdata[POS_W-1:0]),
        .in_val     (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (out_value),
        .out_count  (out_count),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {{(TDATA_W - VAL_W - POS_W){1'b0}}, out_count, out_value};

endmodule
